// File: rtl/tagged_key_record_table_assert.svh
// Assertion macros used by the key record table top level.
`ifndef TAGGED_KEY_RECORD_TABLE_ASSERT_SVH
`define TAGGED_KEY_RECORD_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk and quiet while arst_n is low.
`define TKRT_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tkrt assertion failed");

// Next-cycle implication, sampled on clk and quiet while arst_n is low.
`define TKRT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tkrt assertion failed");

`endif

// File: rtl/tkrt_pkg.sv
// Shared constants, types and command structs of the key record table.
`timescale 1ns / 1ps

package tkrt_pkg;

	localparam int ENTRIES  = 32;
	localparam int TAG_BITS = 32;
	localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	localparam int TAG_IN_W = 32;
	localparam int KEY_W    = 16;
	localparam int SCAN_W   = 16;
	localparam int SSCAN_W  = 8;
	localparam int REC_W    = KEY_W + SSCAN_W;

	typedef logic [TAG_BITS-1:0] tag_t;
	typedef logic [IDX_W-1:0]    idx_t;

	typedef enum logic [1:0] {
		ACT_STORE    = 2'd0,
		ACT_RETRIEVE = 2'd1,
		ACT_CLEAR    = 2'd2
	} action_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic lookup;
		logic finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_blocked;
	} status_t;

endpackage

// File: rtl/tkrt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tkrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                       clk,
	input  logic                                       wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                           wr_data,
	input  logic                                       rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                           rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/tkrt_ctrl.sv
// Controller state machine that sequences capture, lookup and result hand-off.
`timescale 1ns / 1ps

module tkrt_ctrl import tkrt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_READ
	} state_t;

	state_t state_q;
	logic   in_stall_q;
	logic   accept;
	logic   done;

	assign accept = in_valid && !in_stall_q;
	// The result leaves the read state only when the output register can take it.
	assign done   = (state_q == ST_READ) && !status.out_blocked;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_stall_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q    <= ST_LOOK;
						in_stall_q <= 1'b1;
					end
				end
				ST_LOOK: begin
					state_q <= ST_READ;
				end
				ST_READ: begin
					if (done) begin
						state_q    <= ST_IDLE;
						in_stall_q <= 1'b0;
					end
				end
				default: begin
					state_q    <= ST_IDLE;
					in_stall_q <= 1'b0;
				end
			endcase
		end
	end

	assign in_stall    = in_stall_q;
	assign cmd.capture = accept;
	assign cmd.lookup  = (state_q == ST_LOOK);
	assign cmd.finish  = done;

endmodule

// File: rtl/tkrt_dp.sv
// Datapath: tag registers, parallel match, record RAM and output register.
`timescale 1ns / 1ps

module tkrt_dp import tkrt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output status_t             status,
	input  logic [1:0]          action,
	input  logic [TAG_IN_W-1:0] window_tag,
	input  logic [KEY_W-1:0]    key_code,
	input  logic [SCAN_W-1:0]   scan_code,
	input  logic                free_on_hit,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                hit,
	output logic [KEY_W-1:0]    out_key_code,
	output logic [SCAN_W-1:0]   out_scan_code,
	output logic                table_full
);

	// Captured input word.
	logic [1:0]        act_q;
	tag_t              tag_in_q;
	logic [KEY_W-1:0]  key_in_q;
	logic [SCAN_W-1:0] scan_in_q;
	logic              free_in_q;

	tag_t tag_q [ENTRIES];

	logic [ENTRIES-1:0] eq_vec;
	logic [ENTRIES-1:0] cand_vec;
	idx_t               eq_idx;
	idx_t               cand_idx;
	logic               eq_any;
	logic               cand_any;

	logic             hit_q;
	logic             full_q;
	logic             ram_wr;
	logic             ram_rd;
	logic [REC_W-1:0] ram_rdata;

	logic              out_valid_q;
	logic              out_hit_q;
	logic [KEY_W-1:0]  out_key_q;
	logic [SCAN_W-1:0] out_scan_q;
	logic              out_full_q;

	function automatic idx_t first_set(input logic [ENTRIES-1:0] vec);
		idx_t idx;
		idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (vec[i]) begin
				idx = idx_t'(i);
			end
		end
		return idx;
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q     <= action;
			tag_in_q  <= tag_t'(window_tag);
			key_in_q  <= key_code;
			scan_in_q <= scan_code;
			free_in_q <= free_on_hit;
		end
	end

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			eq_vec[i]   = (tag_q[i] == tag_in_q);
			cand_vec[i] = eq_vec[i] || (tag_q[i] == '0);
		end
	end

	assign eq_any   = |eq_vec;
	assign cand_any = |cand_vec;
	assign eq_idx   = first_set(eq_vec);
	assign cand_idx = first_set(cand_vec);

	assign ram_wr = cmd.lookup && (act_q == ACT_STORE) && cand_any;
	assign ram_rd = cmd.lookup && (act_q == ACT_RETRIEVE) && eq_any;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				tag_q[i] <= '0;
			end
		end else if (cmd.lookup) begin
			case (act_q)
				ACT_STORE: begin
					if (cand_any) begin
						tag_q[cand_idx] <= tag_in_q;
					end
				end
				ACT_RETRIEVE: begin
					if (eq_any && free_in_q) begin
						tag_q[eq_idx] <= '0;
					end
				end
				ACT_CLEAR: begin
					for (int i = 0; i < ENTRIES; i++) begin
						if (eq_vec[i]) begin
							tag_q[i] <= '0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			hit_q  <= (act_q == ACT_RETRIEVE) && eq_any;
			full_q <= (act_q == ACT_STORE) && !cand_any;
		end
	end

	tkrt_ram #(
		.WIDTH(REC_W),
		.DEPTH(ENTRIES)
	) u_rec_ram (
		.clk    (clk),
		.wr_en  (ram_wr),
		.wr_addr(cand_idx),
		.wr_data({key_in_q, scan_in_q[SSCAN_W-1:0]}),
		.rd_en  (ram_rd),
		.rd_addr(eq_idx),
		.rd_data(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_hit_q  <= hit_q;
			out_full_q <= full_q;
			out_key_q  <= hit_q ? ram_rdata[REC_W-1:SSCAN_W] : '0;
			out_scan_q <= hit_q ? {{(SCAN_W - SSCAN_W){1'b0}}, ram_rdata[SSCAN_W-1:0]}
			                    : scan_in_q;
		end
	end

	assign status.out_blocked = out_valid_q && out_stall;

	assign out_valid     = out_valid_q;
	assign hit           = out_hit_q;
	assign out_key_code  = out_key_q;
	assign out_scan_code = out_scan_q;
	assign table_full    = out_full_q;

endmodule

// File: rtl/tagged_key_record_table.sv
// The controller walks capture, tag lookup and the registered record RAM read for each word,
// and holds in_stall high meanwhile, so no new word is taken until the last one is done.
// The result waits in an output register, so a stalled output holds only the read step.
// Reset (arst_n low) frees all tag entries at once; key and scan records stay undefined.
`timescale 1ns / 1ps

`include "tagged_key_record_table_assert.svh"

module tagged_key_record_table import tkrt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          action,
	input  logic [TAG_IN_W-1:0] window_tag,
	input  logic [KEY_W-1:0]    key_code,
	input  logic [SCAN_W-1:0]   scan_code,
	input  logic                free_on_hit,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                hit,
	output logic [KEY_W-1:0]    out_key_code,
	output logic [SCAN_W-1:0]   out_scan_code,
	output logic                table_full
);

	cmd_t    cmd;
	status_t status;

	tkrt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.status  (status),
		.cmd     (cmd)
	);

	tkrt_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.action       (action),
		.window_tag   (window_tag),
		.key_code     (key_code),
		.scan_code    (scan_code),
		.free_on_hit  (free_on_hit),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.hit          (hit),
		.out_key_code (out_key_code),
		.out_scan_code(out_scan_code),
		.table_full   (table_full)
	);

	// Only one word is in flight: the input side closes right after an accept.
	`TKRT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	// A result never reports a hit and a full table together.
	`TKRT_ASSERT_IMPL(a_full_excludes_hit, out_valid, !(hit && table_full))
	// A miss always returns a zero key code.
	`TKRT_ASSERT_IMPL(a_miss_zero_key, out_valid && !hit, out_key_code == '0)

endmodule

// File: dv/tb.sv
// Testbench for the key record table: directed and random traffic checked against a table predictor.
`timescale 1ns / 1ps

module tb;
	import tkrt_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int POOL_SIZE = 40;
	localparam int RANDOM_WORDS = 1450;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [1:0]          act;
		logic [TAG_IN_W-1:0] tag;
		logic [KEY_W-1:0]    key;
		logic [SCAN_W-1:0]   scan;
		logic                free;
	} key_word_t;

	typedef struct packed {
		logic              hit;
		logic [KEY_W-1:0]  key;
		logic [SCAN_W-1:0] scan;
		logic              full;
	} lookup_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [1:0]          action = 2'd0;
	logic [TAG_IN_W-1:0] window_tag = '0;
	logic [KEY_W-1:0]    key_code = '0;
	logic [SCAN_W-1:0]   scan_code = '0;
	logic                free_on_hit = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                hit;
	logic [KEY_W-1:0]    out_key_code;
	logic [SCAN_W-1:0]   out_scan_code;
	logic                table_full;

	// Predicted table contents.
	tag_t               rec_tag [ENTRIES];
	logic [KEY_W-1:0]   rec_key [ENTRIES];
	logic [SSCAN_W-1:0] rec_scan [ENTRIES];

	key_word_t      pending_words[$];
	lookup_result_t expected_results[$];
	logic [TAG_IN_W-1:0] tag_pool [POOL_SIZE];

	key_word_t      drive_word;
	lookup_result_t want;
	int failures = 0;
	int cycle_count = 0;
	int idle_left = 0;
	int no_gap_left = 0;
	int hold_left = 0;
	logic stalling = 1'b0;

	tagged_key_record_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.window_tag(window_tag),
		.key_code(key_code),
		.scan_code(scan_code),
		.free_on_hit(free_on_hit),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hit(hit),
		.out_key_code(out_key_code),
		.out_scan_code(out_scan_code),
		.table_full(table_full)
	);

	always #10 clk = ~clk;

	function automatic lookup_result_t predict_lookup(key_word_t w);
		tag_t t;
		lookup_result_t r;
		logic done;
		t = tag_t'(w.tag);
		r.hit = 1'b0;
		r.key = '0;
		r.scan = w.scan;
		r.full = 1'b0;
		done = 1'b0;
		case (w.act)
			ACT_STORE: begin
				r.full = 1'b1;
				for (int i = 0; i < ENTRIES; i++) begin
					if (!done && (rec_tag[i] == '0 || rec_tag[i] == t)) begin
						rec_tag[i] = t;
						rec_key[i] = w.key;
						rec_scan[i] = w.scan[SSCAN_W-1:0];
						r.full = 1'b0;
						done = 1'b1;
					end
				end
			end
			ACT_RETRIEVE: begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (!done && rec_tag[i] == t) begin
						r.hit = 1'b1;
						r.key = rec_key[i];
						r.scan = SCAN_W'(rec_scan[i]);
						if (w.free)
							rec_tag[i] = '0;
						done = 1'b1;
					end
				end
			end
			ACT_CLEAR: begin
				for (int i = 0; i < ENTRIES; i++)
					if (rec_tag[i] == t)
						rec_tag[i] = '0;
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(4, 25);
	endfunction

	task automatic queue_word(logic [1:0] act, logic [TAG_IN_W-1:0] tag,
			logic [KEY_W-1:0] key, logic [SCAN_W-1:0] scan, logic free);
		pending_words.push_back({act, tag, key, scan, free});
	endtask

	task automatic queue_random_word();
		int r;
		logic [1:0] act;
		logic [TAG_IN_W-1:0] tag;
		r = $urandom_range(0, 99);
		if (r < 40)
			act = ACT_STORE;
		else if (r < 78)
			act = ACT_RETRIEVE;
		else if (r < 93)
			act = ACT_CLEAR;
		else
			act = ACT_UNUSED;
		// Mostly a small set of live tags, so stores collide, hits happen and the table fills.
		r = $urandom_range(0, 99);
		if (r < 85)
			tag = tag_pool[$urandom_range(0, POOL_SIZE - 1)];
		else if (r < 93)
			tag = $urandom;
		else
			tag = '0;
		queue_word(act, tag, KEY_W'($urandom_range(0, 65535)),
			SCAN_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
	endtask

	task automatic compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
			failures++;
		end
	endtask

	// Driver: presents pending words, with random gaps between them.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_results.push_back(predict_lookup(
					{action, window_tag, key_code, scan_code, free_on_hit}));
			if (!in_valid || !in_stall) begin
				if (idle_left != 0) begin
					idle_left--;
					in_valid <= 1'b0;
				end else if (pending_words.size() != 0) begin
					drive_word = pending_words.pop_front();
					action <= drive_word.act;
					window_tag <= drive_word.tag;
					key_code <= drive_word.key;
					scan_code <= drive_word.scan;
					free_on_hit <= drive_word.free;
					in_valid <= 1'b1;
					if (no_gap_left != 0)
						no_gap_left--;
					else if ($urandom_range(0, 99) < 3)
						no_gap_left = $urandom_range(20, 80);
					idle_left = (no_gap_left != 0) ? 0 : pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result word and stalls the output at random.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result word, expected none, actual hit=%b key=%h scan=%h full=%b",
						$time, hit, out_key_code, out_scan_code, table_full);
					failures++;
				end else begin
					want = expected_results.pop_front();
					compare_field("hit", 16'(want.hit), 16'(hit));
					compare_field("out_key_code", want.key, out_key_code);
					compare_field("out_scan_code", want.scan, out_scan_code);
					compare_field("table_full", 16'(want.full), 16'(table_full));
				end
			end
			if (hold_left != 0) begin
				hold_left--;
			end else begin
				stalling = ($urandom_range(0, 99) < 35);
				hold_left = stalling ? pick_gap() : $urandom_range(0, 60);
			end
			out_stall <= stalling;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < ENTRIES; i++) begin
			rec_tag[i] = '0;
			rec_key[i] = '0;
			rec_scan[i] = '0;
		end
		tag_pool[0] = 32'hFFFF_FFFF;
		tag_pool[1] = 32'h0000_0001;
		tag_pool[2] = 32'h8000_0000;
		// A distinct nonzero low byte keeps the pool tags unique.
		for (int i = 3; i < POOL_SIZE; i++)
			tag_pool[i] = ($urandom & 32'hFFFF_FF00) | i;

		// Fill every record once; after this a free record never holds unwritten codes.
		for (int i = 0; i < ENTRIES; i++) begin
			if (i == 0)
				queue_word(ACT_STORE, tag_pool[i], 16'hFFFF, 16'hFFFF, 1'b1);
			else if (i == 1)
				queue_word(ACT_STORE, tag_pool[i], 16'h0000, 16'h0000, 1'b0);
			else
				queue_word(ACT_STORE, tag_pool[i], KEY_W'($urandom), SCAN_W'($urandom), 1'b0);
		end
		queue_word(ACT_STORE, tag_pool[32], 16'h1234, 16'hABCD, 1'b0);
		queue_word(ACT_STORE, tag_pool[5], 16'h8001, 16'h7F80, 1'b0);
		queue_word(ACT_RETRIEVE, tag_pool[0], 16'h0000, 16'h5555, 1'b0);
		queue_word(ACT_RETRIEVE, tag_pool[5], 16'hFFFF, 16'h0000, 1'b1);
		queue_word(ACT_RETRIEVE, tag_pool[5], 16'h0000, 16'hFFFF, 1'b0);
		queue_word(ACT_STORE, tag_pool[32], 16'h00FF, 16'h0F0F, 1'b0);
		queue_word(ACT_RETRIEVE, '0, 16'h0000, 16'h0001, 1'b0);
		queue_word(ACT_CLEAR, tag_pool[1], 16'hFFFF, 16'hFFFF, 1'b1);
		queue_word(ACT_RETRIEVE, '0, 16'h0000, 16'h0002, 1'b0);
		queue_word(ACT_STORE, '0, 16'hBEEF, 16'h12C3, 1'b0);
		queue_word(ACT_RETRIEVE, '0, 16'h0000, 16'h0003, 1'b1);
		queue_word(ACT_CLEAR, '0, 16'h0000, 16'h0000, 1'b0);
		queue_word(ACT_UNUSED, tag_pool[0], 16'hFFFF, 16'hFFFF, 1'b1);
		queue_word(ACT_RETRIEVE, tag_pool[0], 16'h0000, 16'h0000, 1'b1);
		queue_word(ACT_RETRIEVE, tag_pool[32], 16'h0000, 16'h0000, 1'b0);
		for (int n = 0; n < RANDOM_WORDS; n++)
			queue_random_word();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_words.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (failures == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
